[design/icf_pkg.sv]
// Shared constants, codes and types for the IR constant folder.
// No dependencies; imported by every module of the block.
package icf_pkg;

    localparam int NUM_REGS  = 256;
    localparam int REG_W     = 8;
    localparam int REG_IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int REG_EXT_W = ((REG_IDX_W > REG_W) ? REG_IDX_W : REG_W) + 1;
    localparam int DATA_W    = 64;
    localparam int CNT_W     = $clog2(DATA_W);
    localparam int FUNC_W    = 3;
    localparam int KIND_W    = 2;
    localparam int TOTAL_W   = 32;

    localparam logic [FUNC_W-1:0] OP_OTHER   = 3'd0;
    localparam logic [FUNC_W-1:0] OP_LOADI   = 3'd1;
    localparam logic [FUNC_W-1:0] OP_ADD     = 3'd2;
    localparam logic [FUNC_W-1:0] OP_SUB     = 3'd3;
    localparam logic [FUNC_W-1:0] OP_MUL     = 3'd4;
    localparam logic [FUNC_W-1:0] OP_DIV     = 3'd5;
    localparam logic [FUNC_W-1:0] OP_BARRIER = 3'd6;

    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REG   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_OTHER = 2'd3;

    typedef logic [FUNC_W-1:0]    func_t;
    typedef logic [KIND_W-1:0]    kind_t;
    typedef logic [DATA_W-1:0]    data_t;
    typedef logic [REG_IDX_W-1:0] ridx_t;

    typedef struct packed {
        logic  start;
        func_t op;
    } alu_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_stat_t;

    typedef struct packed {
        logic  en;
        logic  known;
        logic  clr;
        ridx_t addr;
    } tab_wr_t;

    function automatic logic reg_in_range(input logic [REG_W-1:0] r);
        return REG_EXT_W'(r) < REG_EXT_W'(NUM_REGS);
    endfunction

    function automatic ridx_t reg_index(input logic [REG_W-1:0] r);
        return ridx_t'(r);
    endfunction

endpackage

[design/icf_regtab.sv]
// Constant table: per-register known flags in flops and a value memory.
// Depends on icf_pkg.
module icf_regtab
    import icf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    rd_en,
    input  ridx_t   rd_addr1,
    input  ridx_t   rd_addr2,
    output data_t   rd_data1,
    output data_t   rd_data2,
    output logic    rd_known1,
    output logic    rd_known2,
    input  tab_wr_t wr,
    input  data_t   wr_value
);

    logic [NUM_REGS-1:0] known_reg;
    data_t               mem [NUM_REGS];
    data_t               rd_data1_reg;
    data_t               rd_data2_reg;
    logic                rd_known1_reg;
    logic                rd_known2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            known_reg <= '0;
        end
        else if (wr.clr)
        begin
            known_reg <= '0;
        end
        else if (wr.en)
        begin
            known_reg[wr.addr] <= wr.known;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && wr.known)
        begin
            mem[wr.addr] <= wr_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data1_reg  <= mem[rd_addr1];
            rd_data2_reg  <= mem[rd_addr2];
            rd_known1_reg <= known_reg[rd_addr1];
            rd_known2_reg <= known_reg[rd_addr2];
        end
    end

    assign rd_data1  = rd_data1_reg;
    assign rd_data2  = rd_data2_reg;
    assign rd_known1 = rd_known1_reg;
    assign rd_known2 = rd_known2_reg;

endmodule

[design/icf_alu.sv]
// Iterative 64-bit add, sub, mul and signed div around one shared adder.
// Depends on icf_pkg.
module icf_alu
    import icf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  alu_req_t  req,
    input  data_t     a,
    input  data_t     b,
    output alu_stat_t stat,
    output data_t     result
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_SINGLE = 3'd1;
    localparam logic [2:0] PH_ABSA   = 3'd2;
    localparam logic [2:0] PH_ABSB   = 3'd3;
    localparam logic [2:0] PH_LOOP   = 3'd4;
    localparam logic [2:0] PH_FIX    = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

    logic [2:0]       ph_reg, ph_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    func_t            op_reg, op_next;
    logic             neg_reg, neg_next;
    data_t            acc_reg, acc_next;
    data_t            x_reg, x_next;
    data_t            q_reg, q_next;
    data_t            res_reg, res_next;

    data_t            add_x;
    data_t            add_y;
    logic             add_sub;
    logic [DATA_W:0]  add_sum;
    data_t            shifted;

    assign shifted = {acc_reg[DATA_W-2:0], q_reg[DATA_W-1]};

    always_comb
    begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        unique case (ph_reg)
            PH_SINGLE:
            begin
                add_x   = q_reg;
                add_y   = x_reg;
                add_sub = (op_reg == OP_SUB);
            end
            PH_ABSA:
            begin
                add_y   = q_reg;
                add_sub = 1'b1;
            end
            PH_ABSB:
            begin
                add_y   = x_reg;
                add_sub = 1'b1;
            end
            PH_LOOP:
            begin
                if (op_reg == OP_DIV)
                begin
                    add_x   = shifted;
                    add_y   = x_reg;
                    add_sub = 1'b1;
                end
                else
                begin
                    add_x = acc_reg;
                    add_y = x_reg;
                end
            end
            PH_FIX:
            begin
                add_y   = q_reg;
                add_sub = 1'b1;
            end
            default:
            begin
                add_sub = 1'b0;
            end
        endcase
        add_sum = {1'b0, add_x} + {1'b0, add_y ^ {DATA_W{add_sub}}}
                  + (DATA_W + 1)'(add_sub);
    end

    always_comb
    begin
        ph_next  = ph_reg;
        cnt_next = cnt_reg;
        op_next  = op_reg;
        neg_next = neg_reg;
        acc_next = acc_reg;
        x_next   = x_reg;
        q_next   = q_reg;
        res_next = res_reg;
        unique case (ph_reg)
            PH_IDLE:
            begin
                if (req.start)
                begin
                    op_next  = req.op;
                    q_next   = a;
                    x_next   = b;
                    acc_next = '0;
                    cnt_next = '0;
                    neg_next = a[DATA_W-1] ^ b[DATA_W-1];
                    priority if (req.op == OP_MUL)
                        ph_next = PH_LOOP;
                    else if (req.op == OP_DIV)
                        ph_next = PH_ABSA;
                    else
                        ph_next = PH_SINGLE;
                end
            end
            PH_SINGLE:
            begin
                res_next = add_sum[DATA_W-1:0];
                ph_next  = PH_DONE;
            end
            PH_ABSA:
            begin
                if (q_reg[DATA_W-1])
                    q_next = add_sum[DATA_W-1:0];
                ph_next = PH_ABSB;
            end
            PH_ABSB:
            begin
                if (x_reg[DATA_W-1])
                    x_next = add_sum[DATA_W-1:0];
                ph_next = PH_LOOP;
            end
            PH_LOOP:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (op_reg == OP_DIV)
                begin
                    acc_next = add_sum[DATA_W] ? add_sum[DATA_W-1:0] : shifted;
                    q_next   = {q_reg[DATA_W-2:0], add_sum[DATA_W]};
                    if (cnt_reg == CNT_LAST)
                        ph_next = PH_FIX;
                end
                else
                begin
                    if (q_reg[0])
                        acc_next = add_sum[DATA_W-1:0];
                    x_next = {x_reg[DATA_W-2:0], 1'b0};
                    q_next = {1'b0, q_reg[DATA_W-1:1]};
                    if (cnt_reg == CNT_LAST)
                    begin
                        res_next = acc_next;
                        ph_next  = PH_DONE;
                    end
                end
            end
            PH_FIX:
            begin
                res_next = neg_reg ? add_sum[DATA_W-1:0] : q_reg;
                ph_next  = PH_DONE;
            end
            PH_DONE:
            begin
                ph_next = PH_IDLE;
            end
            default:
            begin
                ph_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg  <= PH_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            ph_reg  <= ph_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        x_reg   <= x_next;
        q_reg   <= q_next;
        res_reg <= res_next;
    end

    assign stat.busy = (ph_reg != PH_IDLE);
    assign stat.done = (ph_reg == PH_DONE);
    assign result    = res_reg;

endmodule

[design/ir_constant_folder.sv]
// IR constant folder top level: handshake, sequencer, fold decision, counter.
// Depends on icf_pkg, icf_regtab and icf_alu.
//
// One instruction is handled at a time; in_ready is high only while the block is
// empty. An instruction that is not folded goes from evaluation straight to the
// output; a folded add or sub makes one pass through the shared 64-bit adder, and
// a folded mul or div steps that adder once per bit. Known flags clear at once on
// reset and on a barrier; no clearing pass is needed.
module ir_constant_folder
    import icf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [FUNC_W-1:0]        func,
    input  logic [KIND_W-1:0]        dest_kind,
    input  logic [REG_W-1:0]         dest_reg,
    input  logic [KIND_W-1:0]        src1_kind,
    input  logic signed [DATA_W-1:0] src1_int,
    input  logic [REG_W-1:0]         src1_reg,
    input  logic [KIND_W-1:0]        src2_kind,
    input  logic signed [DATA_W-1:0] src2_int,
    input  logic [REG_W-1:0]         src2_reg,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [FUNC_W-1:0]        out_func,
    output logic [KIND_W-1:0]        out_src1_kind,
    output logic signed [DATA_W-1:0] out_src1_int,
    output logic [KIND_W-1:0]        out_src2_kind,
    output logic                     folded,
    output logic [TOTAL_W-1:0]       fold_total
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [TOTAL_W-1:0] total_reg;

    func_t              func_reg;
    kind_t              dkind_reg;
    logic [REG_W-1:0]   dreg_reg;
    kind_t              s1k_reg;
    data_t              s1i_reg;
    logic               s1r_ok_reg;
    kind_t              s2k_reg;
    data_t              s2i_reg;
    logic               s2r_ok_reg;

    func_t              o_func_reg;
    kind_t              o_s1k_reg;
    data_t              o_s1i_reg;
    kind_t              o_s2k_reg;
    logic               o_fold_reg;

    logic               accept;
    data_t              rd1, rd2;
    logic               kn1, kn2;
    data_t              op_a, op_b;
    logic               ca, cb, arith, go;
    logic               fin, fold_now;
    func_t              f_func;
    kind_t              f_s1k;
    data_t              f_s1i;
    kind_t              f_s2k;
    alu_req_t           alu_req;
    alu_stat_t          alu_stat;
    data_t              alu_res;
    tab_wr_t            tab_wr;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);

    icf_regtab u_regtab (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr1  (reg_index(src1_reg)),
        .rd_addr2  (reg_index(src2_reg)),
        .rd_data1  (rd1),
        .rd_data2  (rd2),
        .rd_known1 (kn1),
        .rd_known2 (kn2),
        .wr        (tab_wr),
        .wr_value  (f_s1i)
    );

    icf_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (op_a),
        .b      (op_b),
        .stat   (alu_stat),
        .result (alu_res)
    );

    always_comb
    begin
        op_a  = (s1k_reg == KIND_INT) ? s1i_reg : rd1;
        op_b  = (s2k_reg == KIND_INT) ? s2i_reg : rd2;
        ca    = (s1k_reg == KIND_INT) || ((s1k_reg == KIND_REG) && s1r_ok_reg && kn1);
        cb    = (s2k_reg == KIND_INT) || ((s2k_reg == KIND_REG) && s2r_ok_reg && kn2);
        arith = (func_reg == OP_ADD) || (func_reg == OP_SUB)
                || (func_reg == OP_MUL) || (func_reg == OP_DIV);
        go    = arith && ca && cb && !((func_reg == OP_DIV) && (op_b == '0));

        alu_req.start = (state_reg == S_EVAL) && go && !alu_stat.busy;
        alu_req.op    = func_reg;

        fold_now = (state_reg == S_WAIT);
        fin      = ((state_reg == S_EVAL) && !go) || (fold_now && alu_stat.done);

        f_func = fold_now ? OP_LOADI  : func_reg;
        f_s1k  = fold_now ? KIND_INT  : s1k_reg;
        f_s1i  = fold_now ? alu_res   : s1i_reg;
        f_s2k  = fold_now ? KIND_NONE : s2k_reg;

        tab_wr.en    = fin && (dkind_reg == KIND_REG) && reg_in_range(dreg_reg);
        tab_wr.known = (f_func == OP_LOADI) && (f_s1k == KIND_INT);
        tab_wr.clr   = fin && (func_reg == OP_BARRIER);
        tab_wr.addr  = reg_index(dreg_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = go ? S_WAIT : S_OUT;
            end
            S_WAIT:
            begin
                if (alu_stat.done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (fin && fold_now)
                total_reg <= total_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg   <= func;
            dkind_reg  <= dest_kind;
            dreg_reg   <= dest_reg;
            s1k_reg    <= src1_kind;
            s1i_reg    <= $unsigned(src1_int);
            s1r_ok_reg <= reg_in_range(src1_reg);
            s2k_reg    <= src2_kind;
            s2i_reg    <= $unsigned(src2_int);
            s2r_ok_reg <= reg_in_range(src2_reg);
        end
        if (fin)
        begin
            o_func_reg <= f_func;
            o_s1k_reg  <= f_s1k;
            o_s1i_reg  <= f_s1i;
            o_s2k_reg  <= f_s2k;
            o_fold_reg <= fold_now;
        end
    end

    assign out_valid     = (state_reg == S_OUT);
    assign out_func      = o_func_reg;
    assign out_src1_kind = o_s1k_reg;
    assign out_src1_int  = $signed(o_s1i_reg);
    assign out_src2_kind = o_s2k_reg;
    assign folded        = o_fold_reg;
    assign fold_total    = total_reg;

endmodule

[bench/tb_ir_constant_folder.sv]
// Self-checking bench for ir_constant_folder: a directed table, then random
// instruction streams checked against a local model of the constant table.
// Depends on icf_pkg and the design sources under design/.
module tb_ir_constant_folder;
    import icf_pkg::*;

    localparam func_t OP_UNUSED   = 3'd7;
    localparam data_t S64_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam data_t S64_MIN     = 64'h8000_0000_0000_0000;
    localparam data_t S64_NEG1    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int    N_DIR       = 24;
    localparam int    N_RANDOM    = 2000;
    localparam int    LONG_HOLD   = 400;
    localparam int    HOLD_AT     = 700;
    localparam int    DRAIN_TAIL  = 80;
    localparam int    CYCLE_LIMIT = 1000000;
    localparam int    POOL_SIZE   = 8;

    typedef struct packed {
        func_t            op;
        kind_t            dk;
        logic [REG_W-1:0] dr;
        kind_t            k1;
        data_t            i1;
        logic [REG_W-1:0] r1;
        kind_t            k2;
        data_t            i2;
        logic [REG_W-1:0] r2;
    } instr_t;

    typedef struct packed {
        func_t              op;
        kind_t              k1;
        data_t              i1;
        kind_t              k2;
        logic               folded;
        logic [TOTAL_W-1:0] total;
    } fold_res_t;

    typedef struct packed {
        instr_t    it;
        logic      typed;
        fold_res_t res;
    } dir_row_t;

    logic                     clk           = 1'b0;
    logic                     rst_n         = 1'b0;
    logic                     in_valid      = 1'b0;
    logic                     in_ready;
    logic [FUNC_W-1:0]        func          = '0;
    logic [KIND_W-1:0]        dest_kind     = '0;
    logic [REG_W-1:0]         dest_reg      = '0;
    logic [KIND_W-1:0]        src1_kind     = '0;
    logic signed [DATA_W-1:0] src1_int      = '0;
    logic [REG_W-1:0]         src1_reg      = '0;
    logic [KIND_W-1:0]        src2_kind     = '0;
    logic signed [DATA_W-1:0] src2_int      = '0;
    logic [REG_W-1:0]         src2_reg      = '0;
    logic                     out_valid;
    logic                     out_ready     = 1'b0;
    logic [FUNC_W-1:0]        out_func;
    logic [KIND_W-1:0]        out_src1_kind;
    logic signed [DATA_W-1:0] out_src1_int;
    logic [KIND_W-1:0]        out_src2_kind;
    logic                     folded;
    logic [TOTAL_W-1:0]       fold_total;

    logic               const_known [NUM_REGS];
    data_t              const_val   [NUM_REGS];
    logic [TOTAL_W-1:0] fold_count  = '0;
    fold_res_t          fold_q [$];

    logic [REG_W-1:0] live_regs [POOL_SIZE];
    logic             send_burst     = 1'b0;
    logic             recv_burst     = 1'b0;
    logic             long_hold_done = 1'b0;
    int               errors         = 0;
    int               results_seen   = 0;
    int               items_sent     = 0;
    int               cycle_count    = 0;

    dir_row_t dir_rows [N_DIR] = '{
        '{'{OP_ADD, KIND_NONE, 8'd0, KIND_REG, 64'd0, 8'd0, KIND_REG, 64'd0, 8'd1},
          1'b1, '{OP_ADD, KIND_REG, 64'd0, KIND_REG, 1'b0, 32'd0}},
        '{'{OP_ADD, KIND_REG, 8'd200, KIND_INT, S64_MAX, 8'd0, KIND_INT, 64'd1, 8'd0},
          1'b1, '{OP_LOADI, KIND_INT, S64_MIN, KIND_NONE, 1'b1, 32'd1}},
        '{'{OP_SUB, KIND_NONE, 8'd0, KIND_INT, S64_MIN, 8'd0, KIND_INT, 64'd1, 8'd0},
          1'b1, '{OP_LOADI, KIND_INT, S64_MAX, KIND_NONE, 1'b1, 32'd2}},
        '{'{OP_MUL, KIND_OTHER, 8'd255, KIND_INT, S64_MAX, 8'd0, KIND_INT, S64_MAX, 8'd0},
          1'b1, '{OP_LOADI, KIND_INT, 64'd1, KIND_NONE, 1'b1, 32'd3}},
        '{'{OP_DIV, KIND_INT, 8'd0, KIND_INT, S64_MIN, 8'd0, KIND_INT, S64_NEG1, 8'd0},
          1'b1, '{OP_LOADI, KIND_INT, S64_MIN, KIND_NONE, 1'b1, 32'd4}},
        '{'{OP_DIV, KIND_REG, 8'd200, KIND_INT, 64'd7, 8'd0, KIND_INT, 64'd0, 8'd0},
          1'b1, '{OP_DIV, KIND_INT, 64'd7, KIND_INT, 1'b0, 32'd4}},
        '{'{OP_DIV, KIND_NONE, 8'd0, KIND_INT, 64'hFFFF_FFFF_FFFF_FFF9, 8'd0,
            KIND_INT, 64'd2, 8'd0},
          1'b1, '{OP_LOADI, KIND_INT, 64'hFFFF_FFFF_FFFF_FFFD, KIND_NONE, 1'b1, 32'd5}},
        '{'{OP_LOADI, KIND_REG, 8'd5, KIND_INT, 64'd42, 8'd0, KIND_NONE, 64'd0, 8'd0},
          1'b0, '0},
        '{'{OP_ADD, KIND_REG, 8'd6, KIND_REG, 64'd0, 8'd5, KIND_INT, 64'd8, 8'd0},
          1'b0, '0},
        '{'{OP_MUL, KIND_REG, 8'd255, KIND_REG, 64'd0, 8'd6, KIND_REG, 64'd0, 8'd5},
          1'b0, '0},
        '{'{OP_DIV, KIND_REG, 8'd7, KIND_REG, 64'd0, 8'd255, KIND_REG, 64'd0, 8'd200},
          1'b0, '0},
        '{'{OP_SUB, KIND_REG, 8'd0, KIND_REG, S64_NEG1, 8'd255, KIND_REG, S64_MAX, 8'd6},
          1'b0, '0},
        '{'{OP_BARRIER, KIND_REG, 8'd9, KIND_INT, 64'd1, 8'd0, KIND_NONE, 64'd0, 8'd0},
          1'b0, '0},
        '{'{OP_ADD, KIND_NONE, 8'd0, KIND_REG, 64'd0, 8'd5, KIND_INT, 64'd1, 8'd0},
          1'b0, '0},
        '{'{OP_UNUSED, KIND_REG, 8'd5, KIND_INT, 64'd9, 8'd0, KIND_INT, 64'd3, 8'd0},
          1'b0, '0},
        '{'{OP_OTHER, KIND_REG, 8'd4, KIND_INT, 64'd1, 8'd0, KIND_INT, 64'd2, 8'd0},
          1'b0, '0},
        '{'{OP_ADD, KIND_REG, 8'd4, KIND_NONE, 64'h1234_5678_9ABC_DEF0, 8'd3,
            KIND_INT, 64'd3, 8'd0},
          1'b0, '0},
        '{'{OP_ADD, KIND_NONE, 8'd0, KIND_OTHER, S64_MAX, 8'd255, KIND_INT, 64'd5, 8'd0},
          1'b0, '0},
        '{'{OP_LOADI, KIND_REG, 8'd10, KIND_REG, 64'd0, 8'd5, KIND_NONE, 64'd0, 8'd0},
          1'b0, '0},
        '{'{OP_LOADI, KIND_REG, 8'd11, KIND_INT, S64_NEG1, 8'd0, KIND_NONE, 64'd0, 8'd0},
          1'b0, '0},
        '{'{OP_DIV, KIND_REG, 8'd12, KIND_REG, 64'd0, 8'd11, KIND_REG, 64'd0, 8'd11},
          1'b0, '0},
        '{'{OP_MUL, KIND_REG, 8'd11, KIND_REG, 64'd0, 8'd11, KIND_REG, 64'd0, 8'd3},
          1'b0, '0},
        '{'{OP_ADD, KIND_NONE, 8'd0, KIND_REG, 64'd0, 8'd11, KIND_INT, 64'd0, 8'd0},
          1'b0, '0},
        '{'{OP_ADD, KIND_INT, 8'd0, KIND_INT, S64_MIN, 8'd0, KIND_INT, S64_MIN, 8'd0},
          1'b0, '0}
    };

    ir_constant_folder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .dest_kind     (dest_kind),
        .dest_reg      (dest_reg),
        .src1_kind     (src1_kind),
        .src1_int      (src1_int),
        .src1_reg      (src1_reg),
        .src2_kind     (src2_kind),
        .src2_int      (src2_int),
        .src2_reg      (src2_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_func      (out_func),
        .out_src1_kind (out_src1_kind),
        .out_src1_int  (out_src1_int),
        .out_src2_kind (out_src2_kind),
        .folded        (folded),
        .fold_total    (fold_total)
    );

    always #2 clk = ~clk;

    function automatic logic operand_const(input kind_t k, input data_t imm,
                                           input logic [REG_W-1:0] r, output data_t v);
        v = '0;
        if (k == KIND_INT)
        begin
            v = imm;
            return 1'b1;
        end
        if (k == KIND_REG && int'(r) < NUM_REGS && const_known[r])
        begin
            v = const_val[r];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic data_t trunc_div(input data_t a, input data_t b);
        data_t ma, mb, q;
        ma = a[DATA_W-1] ? -a : a;
        mb = b[DATA_W-1] ? -b : b;
        q  = ma / mb;
        return (a[DATA_W-1] != b[DATA_W-1]) ? -q : q;
    endfunction

    function automatic fold_res_t fold_predict(input instr_t it);
        fold_res_t r;
        data_t     a, b, v;
        logic      ca, cb, ok;
        r.op     = it.op;
        r.k1     = it.k1;
        r.i1     = it.i1;
        r.k2     = it.k2;
        r.folded = 1'b0;
        ok       = 1'b0;
        v        = '0;
        ca = operand_const(it.k1, it.i1, it.r1, a);
        cb = operand_const(it.k2, it.i2, it.r2, b);
        if (it.op >= OP_ADD && it.op <= OP_DIV && ca && cb)
        begin
            ok = 1'b1;
            case (it.op)
                OP_ADD:  v = a + b;
                OP_SUB:  v = a - b;
                OP_MUL:  v = a * b;
                default:
                begin
                    if (b != '0)
                        v = trunc_div(a, b);
                    else
                        ok = 1'b0;
                end
            endcase
        end
        if (ok)
        begin
            r.op       = OP_LOADI;
            r.k1       = KIND_INT;
            r.i1       = v;
            r.k2       = KIND_NONE;
            r.folded   = 1'b1;
            fold_count = fold_count + 1'b1;
        end
        r.total = fold_count;
        if (it.dk == KIND_REG && int'(it.dr) < NUM_REGS)
        begin
            const_known[it.dr] = (r.op == OP_LOADI && r.k1 == KIND_INT);
            if (const_known[it.dr])
                const_val[it.dr] = r.i1;
        end
        if (it.op == OP_BARRIER)
            foreach (const_known[i]) const_known[i] = 1'b0;
        return r;
    endfunction

    function automatic int draw_gap(inout logic burst);
        if ($urandom_range(0, 39) == 0)
            burst = ~burst;
        return burst ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic void refresh_pool();
        foreach (live_regs[i]) live_regs[i] = REG_W'($urandom);
    endfunction

    function automatic logic [REG_W-1:0] pool_reg();
        return live_regs[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic data_t pick_value();
        case ($urandom_range(0, 4))
            0:       return data_t'($urandom_range(0, 16));
            1:       return -data_t'($urandom_range(1, 16));
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       return S64_MIN;
                    1:       return S64_MAX;
                    2:       return S64_NEG1;
                    default: return '0;
                endcase
            end
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void pick_source(output kind_t k, inout data_t imm,
                                        inout logic [REG_W-1:0] r);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3)
        begin
            k   = KIND_INT;
            imm = pick_value();
        end
        else if (sel < 9)
        begin
            k = KIND_REG;
            r = pool_reg();
        end
        else
            k = kind_t'($urandom);
    endfunction

    function automatic instr_t random_instr();
        instr_t it;
        int     sel;
        it.op = func_t'($urandom);
        it.dk = kind_t'($urandom);
        it.dr = REG_W'($urandom);
        it.k1 = kind_t'($urandom);
        it.i1 = {$urandom, $urandom};
        it.r1 = REG_W'($urandom);
        it.k2 = kind_t'($urandom);
        it.i2 = {$urandom, $urandom};
        it.r2 = REG_W'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 12)
            return it;
        if (sel < 30)
        begin
            it.op = OP_LOADI;
            it.dk = KIND_REG;
            it.dr = pool_reg();
            it.k1 = KIND_INT;
            it.i1 = pick_value();
        end
        else if (sel < 86)
        begin
            it.op = func_t'(OP_ADD + $urandom_range(0, 3));
            if ($urandom_range(0, 9) < 8)
            begin
                it.dk = KIND_REG;
                it.dr = pool_reg();
            end
            pick_source(it.k1, it.i1, it.r1);
            pick_source(it.k2, it.i2, it.r2);
        end
        else if (sel < 91)
        begin
            it.op = OP_BARRIER;
            refresh_pool();
        end
        else
        begin
            case ($urandom_range(0, 2))
                0:       it.op = OP_OTHER;
                1:       it.op = OP_UNUSED;
                default: it.op = OP_LOADI;
            endcase
            it.dk = KIND_REG;
            it.dr = pool_reg();
            if (it.op == OP_LOADI)
                pick_source(it.k1, it.i1, it.r1);
        end
        return it;
    endfunction

    task automatic send_instr(input instr_t it, input logic typed, input fold_res_t want);
        int        gap;
        fold_res_t pred;
        gap = draw_gap(send_burst);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= it.op;
        dest_kind <= it.dk;
        dest_reg  <= it.dr;
        src1_kind <= it.k1;
        src1_int  <= it.i1;
        src1_reg  <= it.r1;
        src2_kind <= it.k2;
        src2_int  <= it.i2;
        src2_reg  <= it.r2;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pred = fold_predict(it);
        fold_q.push_back(typed ? want : pred);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (fold_q.size() != 0) @(posedge clk);
    endtask

    // Receiver: random backpressure, one long hold-off to fill the block.
    initial
    begin
        int gap;
        forever
        begin
            gap = draw_gap(recv_burst);
            if (!long_hold_done && results_seen >= HOLD_AT)
            begin
                gap            = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        fold_res_t got, want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{out_func, out_src1_kind, out_src1_int, out_src2_kind, folded, fold_total};
            results_seen++;
            if (fold_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result with nothing pending: func=%0d s1k=%0d s1i=%h",
                             got.op, got.k1, got.i1);
            end
            else
            begin
                want = fold_q.pop_front();
                if (got.op !== want.op || got.k1 !== want.k1 || got.i1 !== want.i1 ||
                    got.k2 !== want.k2 || got.folded !== want.folded ||
                    got.total !== want.total)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("ERROR: result %0d exp func=%0d s1k=%0d s1i=%h s2k=%0d %s",
                                 results_seen, want.op, want.k1, want.i1, want.k2,
                                 $sformatf("fold=%0b total=%0d", want.folded, want.total));
                        $display("       got func=%0d s1k=%0d s1i=%h s2k=%0d %s",
                                 got.op, got.k1, got.i1, got.k2,
                                 $sformatf("fold=%0b total=%0d", got.folded, got.total));
                    end
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int n;
        foreach (const_known[i]) const_known[i] = 1'b0;
        foreach (const_val[i]) const_val[i] = '0;
        refresh_pool();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < N_DIR; n++)
            send_instr(dir_rows[n].it, dir_rows[n].typed, dir_rows[n].res);
        wait_drained();

        for (n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM / 2)
                wait_drained();
            send_instr(random_instr(), 1'b0, '0);
        end
        wait_drained();
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("Ran %0d instructions (%0d from the table) with %0d folds, random stalls,",
                 items_sent, N_DIR, fold_count);
        $display("one long output hold-off and drained pauses; %0d mismatches.", errors);
        if (errors == 0 && fold_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
